// ===== src/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// shared types and constants for the first-fit arena allocator
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int ARENA_BYTES_DEF  = 4096;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int MAX_BLOCKS_DEF   = 256;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FIRST_BIG = 3'd1;
  localparam logic [2:0] ST_NO_MEM    = 3'd2;
  localparam logic [2:0] ST_NULL      = 3'd3;
  localparam logic [2:0] ST_OUTSIDE   = 3'd4;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd5;

  typedef struct packed {
    logic        action;
    logic [15:0] request_size;
    logic        free_is_null;
    logic [12:0] free_offset;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] payload_offset;
  } out_item_t;

endpackage

// ===== src/first_fit_arena_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_arena_allocator
// first-fit allocator walking an address-ordered chain of block records
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | ffa_pkg::in_item_t
// out     | output    | out_valid/out_stall| ffa_pkg::out_item_t
//
// an allocate visits each chain record through a read, successor read, merge
// check and decide step, with a successor fetch and another merge check when
// a record is merged with its successor, and a spare-record scan of up to
// MAX_BLOCKS records plus one link write when a new record is placed; a free
// visits each record through a read and a check step. every item passes an
// accept and a done step before its result; the memory reads one record per
// cycle. synchronous reset clears only the control state, the empty flag,
// out_full and the pool busy bits. a waiting result holds while out_stall is
// high and the next item is taken once the result register is free.
// ----------------------------------------------------------------------------
module first_fit_arena_allocator #(
  parameter int ARENA_BYTES  = ffa_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS   = ffa_pkg::MAX_BLOCKS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ffa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ffa_pkg::out_item_t out_data
);

  localparam int IW = $clog2(MAX_BLOCKS);   // record index
  localparam int LW = IW + 1;               // link, value MAX_BLOCKS means none
  localparam int AW = 18;                   // offsets and sizes, any request plus header
  localparam logic [LW-1:0] NO_LINK = LW'(MAX_BLOCKS);
  localparam logic [AW-1:0] HDR     = AW'(HEADER_BYTES);
  localparam logic [AW-1:0] ARENA   = AW'(ARENA_BYTES);

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RCUR  = 4'd1;  // read current record
  localparam logic [3:0] S_RNXT  = 4'd2;  // read successor
  localparam logic [3:0] S_MERGE = 4'd3;  // merge check on the successor
  localparam logic [3:0] S_DEC   = 4'd4;  // fit decisions
  localparam logic [3:0] S_SCAN  = 4'd5;  // hunt for a spare record
  localparam logic [3:0] S_PLACE = 4'd6;
  localparam logic [3:0] S_FRD   = 4'd7;  // free walk read
  localparam logic [3:0] S_FCHK  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_RLINK = 4'd10; // read successor of a merged record

  // record memory, one word per record
  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW-1:0] size;
    logic          used;
    logic [LW-1:0] link;
  } rec_t;

  rec_t mem [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] busy;
  logic                  started;

  logic [3:0]    state;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  rec_t          rd_q;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  rec_t          wr_d;

  ffa_pkg::in_item_t req;
  rec_t          cur_r, nxt_r;
  logic [IW-1:0] cur;
  logic [IW-1:0] scan;
  logic [LW-1:0] guard;
  logic          merged;
  logic          out_full;

  logic [AW-1:0] req_sz;
  logic [AW-1:0] gap_at, end_at;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_d;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  assign req_sz = AW'(req.request_size);
  assign gap_at = cur_r.start + cur_r.size + HDR;
  assign end_at = (cur_r.link != NO_LINK) ? nxt_r.start : ARENA;
  assign in_stall = (state != S_IDLE) || out_full;
  assign out_valid = out_full;

  // merged record, built from current and the successor just read
  rec_t mrg;
  always_comb begin
    mrg      = cur_r;
    mrg.size = cur_r.size + rd_q.size + HDR;
    mrg.link = rd_q.link;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur;
    unique case (state)
      S_RCUR, S_FRD: rd_en = 1'b1;
      S_RNXT: begin
        // rd_q holds the current record here
        rd_en   = 1'b1;
        rd_addr = rd_q.link[IW-1:0];
      end
      S_RLINK: begin
        rd_en   = 1'b1;
        rd_addr = cur_r.link[IW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    logic we;
    we = 1'b0;
    if (rst) begin
      state    <= S_IDLE;
      started  <= 1'b0;
      busy     <= '0;
      out_full <= 1'b0;
    end else begin
      if (out_full && !out_stall) out_full <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            req   <= in_data;
            cur   <= '0;
            guard <= '0;
            if (in_data.action == ffa_pkg::ACT_FREE) begin
              if (in_data.free_is_null) begin
                out_data <= {ffa_pkg::ST_NULL, 12'd0};
                state    <= S_DONE;
              end else if (AW'(in_data.free_offset) > ARENA) begin
                out_data <= {ffa_pkg::ST_OUTSIDE, 12'd0};
                state    <= S_DONE;
              end else if (!started) begin
                out_data <= {ffa_pkg::ST_NOT_ALLOC, 12'd0};
                state    <= S_DONE;
              end else begin
                state <= S_FRD;
              end
            end else if (!started) begin
              if (AW'(in_data.request_size) + HDR >= ARENA) begin
                out_data <= {ffa_pkg::ST_FIRST_BIG, 12'd0};
              end else begin
                busy[0] <= 1'b1;
                started <= 1'b1;
                we       = 1'b1;
                wr_addr <= '0;
                wr_d    <= '{start: '0, size: AW'(in_data.request_size),
                             used: 1'b1, link: NO_LINK};
                out_data <= {ffa_pkg::ST_OK, 12'(HEADER_BYTES)};
              end
              state <= S_DONE;
            end else begin
              state <= S_RCUR;
            end
          end
        end
        S_RCUR: begin
          merged <= 1'b0;
          state  <= S_RNXT;
        end
        S_RNXT: begin
          // rd_q holds the current record now
          cur_r <= rd_q;
          state <= S_MERGE;
        end
        S_RLINK: state <= S_MERGE;
        S_MERGE: begin
          nxt_r <= rd_q;
          if (!merged && !cur_r.used && cur_r.link != NO_LINK && !rd_q.used) begin
            // fold successor in, then fetch the new successor
            merged <= 1'b1;
            busy[cur_r.link[IW-1:0]] <= 1'b0;
            cur_r   <= mrg;
            we       = 1'b1;
            wr_addr <= cur;
            wr_d    <= mrg;
            state   <= S_RLINK;
          end else begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          if (!cur_r.used && cur_r.size >= req_sz) begin
            we       = 1'b1;
            wr_addr <= cur;
            wr_d    <= '{start: cur_r.start, size: req_sz, used: 1'b1,
                         link: cur_r.link};
            out_data <= {ffa_pkg::ST_OK, 12'(cur_r.start + HDR)};
            state    <= S_DONE;
          end else if (end_at >= gap_at && end_at - gap_at >= HDR + req_sz) begin
            scan  <= '0;
            state <= S_SCAN;
          end else if (cur_r.link == NO_LINK || guard == LW'(MAX_BLOCKS)) begin
            out_data <= {ffa_pkg::ST_NO_MEM, 12'd0};
            state    <= S_DONE;
          end else begin
            cur   <= cur_r.link[IW-1:0];
            guard <= guard + 1'b1;
            state <= S_RCUR;
          end
        end
        S_SCAN: begin
          if (!busy[scan]) begin
            busy[scan] <= 1'b1;
            we       = 1'b1;
            wr_addr <= scan;
            wr_d    <= '{start: gap_at, size: req_sz, used: 1'b1,
                         link: cur_r.link};
            state   <= S_PLACE;
          end else if (scan == IW'(MAX_BLOCKS - 1)) begin
            out_data <= {ffa_pkg::ST_NO_MEM, 12'd0};
            state    <= S_DONE;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_PLACE: begin
          we       = 1'b1;
          wr_addr <= cur;
          wr_d    <= '{start: cur_r.start, size: cur_r.size, used: cur_r.used,
                       link: LW'(scan)};
          out_data <= {ffa_pkg::ST_OK, 12'(gap_at + HDR)};
          state    <= S_DONE;
        end
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          if (rd_q.start + HDR == AW'(req.free_offset)) begin
            if (!rd_q.used) begin
              out_data <= {ffa_pkg::ST_NOT_ALLOC, 12'd0};
            end else begin
              we       = 1'b1;
              wr_addr <= cur;
              wr_d    <= '{start: rd_q.start, size: rd_q.size, used: 1'b0,
                           link: rd_q.link};
              out_data <= {ffa_pkg::ST_OK, 12'd0};
            end
            state <= S_DONE;
          end else if (rd_q.link == NO_LINK || guard == LW'(MAX_BLOCKS)) begin
            out_data <= {ffa_pkg::ST_NOT_ALLOC, 12'd0};
            state    <= S_DONE;
          end else begin
            cur   <= rd_q.link[IW-1:0];
            guard <= guard + 1'b1;
            state <= S_FRD;
          end
        end
        S_DONE: begin
          out_full <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
    wr_en <= we;
  end

`ifndef NO_ASSERTIONS
  // a result is raised only right after the done step
  a_out_after_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE) else $error("stray result");
  // no item taken while a result is still held
  a_no_take_full: assert property (@(posedge clk) disable iff (rst)
    out_full |-> in_stall) else $error("item taken over a held result");
  // head record stays busy once the chain has started
  a_head_busy: assert property (@(posedge clk) disable iff (rst)
    started |-> busy[0]) else $error("head record released");
`endif

endmodule
